// ----- design/free_extent_log2_score_tracker_macros.svh -----
// Assertion macros for the free extent score tracker checker.
// The checker scope must provide clk and rst; checks are off during reset.
`ifndef FREE_EXTENT_LOG2_SCORE_TRACKER_MACROS_SVH
`define FREE_EXTENT_LOG2_SCORE_TRACKER_MACROS_SVH

// Same-cycle implication: when ante holds, cons must hold at that edge.
`define FELST_ASSERT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("felst check failed");

// Next-cycle implication: when ante holds, cons must hold at the next edge.
`define FELST_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("felst check failed");

`endif

// ----- design/felst_pkg.sv -----
// Shared types, codes and the fixed scale table of the free extent score tracker.
// No dependencies; imported by the controller, the datapath and the top level.
`timescale 1ns / 1ps
`default_nettype none

package felst_pkg;

  localparam int SCALE_W = 24;
  localparam int SCORE_W = 64;
  localparam int WORD_W  = 64;
  localparam int ACC_W   = 96;
  localparam int PROD_W  = 58;
  localparam int BIDX_W  = 6;
  localparam int GRP_W   = 3;
  localparam int APB_W   = 32;

  // Register index decoded from paddr[2].
  localparam logic REG_TOP_BUCKET = 1'b0;
  localparam logic [BIDX_W-1:0] TOP_BUCKET_RESET = 6'd48;

  typedef enum logic [1:0] {
    OP_FREE   = 2'd0,
    OP_OCCUPY = 2'd1,
    OP_SCORE  = 2'd2,
    OP_NONE   = 2'd3
  } felst_op_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECODE,
    ST_LZ_BIT,
    ST_UPD_RD0,
    ST_UPD_WR0,
    ST_UPD_WR1,
    ST_Q_RD,
    ST_Q_MLO,
    ST_Q_MHI,
    ST_Q_ACC,
    ST_Q_SAT,
    ST_OUT
  } felst_state_t;

  typedef struct packed {
    logic load_item;
    logic res_clear;
    logic lz_group;
    logic lz_bit;
    logic upd_rd0;
    logic upd_wr0;
    logic upd_wr1;
    logic q_start;
    logic q_rd;
    logic q_mlo;
    logic q_mhi;
    logic q_acc;
    logic q_sat;
    logic out_load;
  } felst_cmd_t;

  typedef struct packed {
    felst_op_t op;
    logic      len_zero;
    logic      last_zero;
    logic      v_last;
    logic      out_busy;
  } felst_sts_t;

  // Unsigned Q8.16 weight per bucket: 1.2 growth up to bucket 20, a linear
  // ramp back toward 1.0 up to bucket 26, flat from bucket 27 on.
  function automatic logic [SCALE_W-1:0] scale_q16(input logic [BIDX_W-1:0] idx);
    logic [SCALE_W-1:0] s;
    unique case (idx)
      6'd0:    s = 24'd65536;
      6'd1:    s = 24'd78643;
      6'd2:    s = 24'd94372;
      6'd3:    s = 24'd113246;
      6'd4:    s = 24'd135895;
      6'd5:    s = 24'd163074;
      6'd6:    s = 24'd195689;
      6'd7:    s = 24'd234827;
      6'd8:    s = 24'd281792;
      6'd9:    s = 24'd338150;
      6'd10:   s = 24'd405780;
      6'd11:   s = 24'd486936;
      6'd12:   s = 24'd584323;
      6'd13:   s = 24'd701188;
      6'd14:   s = 24'd841426;
      6'd15:   s = 24'd1009711;
      6'd16:   s = 24'd1211653;
      6'd17:   s = 24'd1453984;
      6'd18:   s = 24'd1744781;
      6'd19:   s = 24'd2093737;
      6'd20:   s = 24'd2512484;
      6'd21:   s = 24'd2943196;
      6'd22:   s = 24'd3363653;
      6'd23:   s = 24'd3748070;
      6'd24:   s = 24'd4069333;
      6'd25:   s = 24'd4301866;
      default: s = 24'd4424776;
    endcase
    return s;
  endfunction

endpackage

`default_nettype wire

// ----- design/free_extent_log2_score_tracker.sv -----
// Free extent fragmentation score tracker, top level.
//
// Items arrive on the s_ stream: s_tuser carries the operation (free, occupy,
// score query) and s_tdata carries the extent length. Each accepted item gives
// exactly one result item on the m_ stream: m_tdata is the signed Q.16 score
// (zero for updates) and m_tuser is the zero-length error flag.
// The APB port holds one register, top_bucket, at byte address 0.
//
// The block works on one item at a time. An update does two steps of
// leading-one search on the length and two read-modify-writes of the
// bucket RAM. A zero-length update or an unused operation code goes
// straight to the output register. A score query walks buckets
// 1..min(top_bucket, BUCKET_COUNT-1) through one shared 25x33 multiplier:
// per bucket it reads, multiplies the low and high halves, then accumulates.
// Results sit in an output register: a new item is accepted while a finished
// result waits there, and a stalled receiver only holds the block once the
// next result is ready to be written.
// Reset clears the control state, the bucket valid bits (all buckets read
// as zero) and sets top_bucket to 48; no clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none

module free_extent_log2_score_tracker import felst_pkg::*; #(
  parameter int BUCKET_COUNT = 64,
  parameter int LEN_BITS     = 48
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  // Input item stream.
  input  wire logic                               s_tvalid,
  output logic                                    s_tready,
  // tdata: length[LEN_BITS-1:0], zero padding up to a whole byte.
  input  wire logic [((LEN_BITS + 7) / 8) * 8-1:0] s_tdata,
  // tuser: operation[1:0].
  input  wire logic [1:0]                         s_tuser,
  // Result item stream.
  output logic                                    m_tvalid,
  input  wire logic                               m_tready,
  // tdata: score[63:0].
  output logic [SCORE_W-1:0]                      m_tdata,
  // tuser: error[0].
  output logic                                    m_tuser,
  // Configuration port.
  input  wire logic                               psel,
  input  wire logic                               penable,
  input  wire logic                               pwrite,
  input  wire logic [2:0]                         paddr,
  input  wire logic [APB_W-1:0]                   pwdata,
  output logic [APB_W-1:0]                        prdata,
  output logic                                    pready
);

  logic [BIDX_W-1:0] top_bucket;
  logic              reg_sel;
  felst_cmd_t        cmd;
  felst_sts_t        sts;

  // Register index is the word address; byte offset bits are ignored.
  assign reg_sel = paddr[2];
  assign pready  = 1'b1;
  assign prdata  = (reg_sel == REG_TOP_BUCKET) ? APB_W'(top_bucket) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      top_bucket <= TOP_BUCKET_RESET;
    end else if (psel && penable && pwrite && pready && (reg_sel == REG_TOP_BUCKET)) begin
      top_bucket <= pwdata[BIDX_W-1:0];
    end
  end

  felst_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  felst_dp #(
    .BUCKET_COUNT (BUCKET_COUNT),
    .LEN_BITS     (LEN_BITS)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .sts        (sts),
    .in_op      (s_tuser),
    .in_length  (s_tdata[LEN_BITS-1:0]),
    .top_bucket (top_bucket),
    .m_tready   (m_tready),
    .m_tvalid   (m_tvalid),
    .m_tdata    (m_tdata),
    .m_tuser    (m_tuser)
  );

endmodule

`default_nettype wire

// ----- design/felst_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module felst_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ----- design/felst_ctrl.sv -----
// Sequencing state machine of the free extent score tracker.
// Depends on felst_pkg; drives the datapath through felst_cmd_t.
`timescale 1ns / 1ps
`default_nettype none

module felst_ctrl import felst_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       s_tvalid,
  output logic            s_tready,
  input  wire felst_sts_t sts,
  output felst_cmd_t      cmd
);

  felst_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    s_tready   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          cmd.load_item = 1'b1;
          state_next    = ST_DECODE;
        end
      end
      ST_DECODE: begin
        cmd.res_clear = 1'b1;
        unique case (sts.op)
          OP_FREE, OP_OCCUPY: begin
            if (sts.len_zero) begin
              state_next = ST_OUT;
            end else begin
              cmd.lz_group = 1'b1;
              state_next   = ST_LZ_BIT;
            end
          end
          OP_SCORE: begin
            cmd.q_start = 1'b1;
            state_next  = sts.last_zero ? ST_Q_SAT : ST_Q_RD;
          end
          default: begin
            state_next = ST_OUT;
          end
        endcase
      end
      ST_LZ_BIT: begin
        cmd.lz_bit = 1'b1;
        state_next = ST_UPD_RD0;
      end
      ST_UPD_RD0: begin
        cmd.upd_rd0 = 1'b1;
        state_next  = ST_UPD_WR0;
      end
      ST_UPD_WR0: begin
        cmd.upd_wr0 = 1'b1;
        state_next  = ST_UPD_WR1;
      end
      ST_UPD_WR1: begin
        cmd.upd_wr1 = 1'b1;
        state_next  = ST_OUT;
      end
      ST_Q_RD: begin
        cmd.q_rd   = 1'b1;
        state_next = ST_Q_MLO;
      end
      ST_Q_MLO: begin
        cmd.q_mlo  = 1'b1;
        state_next = ST_Q_MHI;
      end
      ST_Q_MHI: begin
        cmd.q_mhi  = 1'b1;
        state_next = ST_Q_ACC;
      end
      ST_Q_ACC: begin
        cmd.q_acc  = 1'b1;
        state_next = sts.v_last ? ST_Q_SAT : ST_Q_RD;
      end
      ST_Q_SAT: begin
        cmd.q_sat  = 1'b1;
        state_next = ST_OUT;
      end
      ST_OUT: begin
        if (!sts.out_busy) begin
          cmd.out_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// ----- design/felst_dp.sv -----
// Datapath of the free extent score tracker: log2 split, bucket read-modify-write,
// score multiply-accumulate, saturation and output register.
// Depends on felst_pkg and felst_ram.
`timescale 1ns / 1ps
`default_nettype none

module felst_dp import felst_pkg::*; #(
  parameter int BUCKET_COUNT = 64,
  parameter int LEN_BITS     = 48
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire felst_cmd_t          cmd,
  output felst_sts_t               sts,
  input  wire logic [1:0]          in_op,
  input  wire logic [LEN_BITS-1:0] in_length,
  input  wire logic [BIDX_W-1:0]   top_bucket,
  input  wire logic                m_tready,
  output logic                     m_tvalid,
  output logic [SCORE_W-1:0]       m_tdata,
  output logic                     m_tuser
);

  localparam int AW    = $clog2(BUCKET_COUNT);
  localparam int NGRP  = (LEN_BITS + 7) / 8;
  localparam int PAD_W = NGRP * 8;
  localparam logic [BIDX_W:0]   NB_LIM   = (BIDX_W + 1)'(BUCKET_COUNT);
  localparam logic [BIDX_W-1:0] LAST_MAX = BIDX_W'(BUCKET_COUNT - 1);

  felst_op_t            op;
  logic [LEN_BITS-1:0]  len;
  logic [GRP_W-1:0]     grp, grp_next;
  logic [2:0]           bitpos;
  logic [BIDX_W-1:0]    sc;
  logic [BIDX_W:0]      sc1;
  logic                 in0, in1;
  logic [WORD_W-1:0]    amt_lo, amt_hi, len64, pow1;
  logic [PAD_W-1:0]     len_pad;
  logic [7:0]           chunk;

  logic [BIDX_W-1:0]    v, last;
  logic [SCALE_W-1:0]   scale;
  logic signed [SCALE_W:0]  mul_a;
  logic signed [32:0]       mul_b;
  logic signed [PROD_W-1:0] prod_full, prod;
  logic [ACC_W-1:0]     acc;
  logic [ACC_W-1:0]     prod_ext, prod_sh;
  logic [ACC_W-64:0]    acc_hi;
  logic [SCORE_W-1:0]   sat;
  logic [SCORE_W-1:0]   res_score;
  logic                 res_error;

  logic [BUCKET_COUNT-1:0] valid;
  logic                 rvalid;
  logic                 re, we;
  logic [AW-1:0]        raddr, waddr;
  logic [WORD_W-1:0]    rdata, rword, wdata, amount;

  felst_ram #(
    .WIDTH (WORD_W),
    .DEPTH (BUCKET_COUNT)
  ) u_bucket_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (re),
    .raddr (raddr),
    .rdata (rdata)
  );

  // Leading-one search in two steps: nonzero byte group first, then the bit.
  assign len_pad = PAD_W'(len);

  always_comb begin
    grp_next = '0;
    for (int g = 0; g < NGRP; g++) begin
      if (|len_pad[g*8 +: 8]) begin
        grp_next = GRP_W'(g);
      end
    end
  end

  assign chunk = len_pad[grp*8 +: 8];

  always_comb begin
    bitpos = '0;
    for (int b = 0; b < 8; b++) begin
      if (chunk[b]) begin
        bitpos = 3'(b);
      end
    end
  end

  assign sc1   = {1'b0, sc} + (BIDX_W + 1)'(1);
  assign in0   = {1'b0, sc} < NB_LIM;
  assign in1   = sc1 < NB_LIM;
  assign len64 = WORD_W'(len);
  assign pow1  = WORD_W'(1) << sc1;

  // Bucket memory access; entries never written read as zero.
  assign rword  = rvalid ? rdata : '0;
  assign re     = (cmd.upd_rd0 && in0) || (cmd.upd_wr0 && in1) || cmd.q_rd;
  assign raddr  = cmd.q_rd ? v[AW-1:0] : (cmd.upd_wr0 ? sc1[AW-1:0] : sc[AW-1:0]);
  assign we     = (cmd.upd_wr0 && in0) || (cmd.upd_wr1 && in1);
  assign waddr  = cmd.upd_wr1 ? sc1[AW-1:0] : sc[AW-1:0];
  assign amount = cmd.upd_wr1 ? amt_hi : amt_lo;
  assign wdata  = (op == OP_OCCUPY) ? (rword - amount) : (rword + amount);

  // Signed 64-bit weight times unsigned scale, taken as two 32-bit halves.
  assign mul_a     = $signed({1'b0, scale});
  assign mul_b     = cmd.q_mlo ? $signed({1'b0, rword[31:0]})
                               : $signed({rword[63], rword[63:32]});
  assign prod_full = mul_a * mul_b;
  assign prod_ext  = {{(ACC_W - PROD_W){prod[PROD_W-1]}}, prod};
  assign prod_sh   = {{(ACC_W - PROD_W - 32){prod[PROD_W-1]}}, prod, 32'b0};

  assign acc_hi = acc[ACC_W-1:63];
  always_comb begin
    if ((&acc_hi) || !(|acc_hi)) begin
      sat = acc[SCORE_W-1:0];
    end else if (acc[ACC_W-1]) begin
      sat = {1'b1, {(SCORE_W - 1){1'b0}}};
    end else begin
      sat = {1'b0, {(SCORE_W - 1){1'b1}}};
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      op  <= felst_op_t'(in_op);
      len <= in_length;
    end
    if (cmd.lz_group) begin
      grp <= grp_next;
    end
    if (cmd.lz_bit) begin
      sc <= BIDX_W'({grp, bitpos});
    end
    if (cmd.upd_rd0) begin
      amt_lo <= pow1 - len64;
      amt_hi <= (len64 << 1) - pow1;
    end
    if (cmd.q_start) begin
      v    <= BIDX_W'(1);
      last <= (top_bucket > LAST_MAX) ? LAST_MAX : top_bucket;
      acc  <= '0;
    end
    if (cmd.q_rd) begin
      scale <= scale_q16(v);
    end
    if (cmd.q_mlo || cmd.q_mhi) begin
      prod <= prod_full;
    end
    if (cmd.q_mhi) begin
      acc <= acc + prod_ext;
    end
    if (cmd.q_acc) begin
      acc <= acc + prod_sh;
      v   <= v + BIDX_W'(1);
    end
    if (cmd.res_clear) begin
      res_score <= '0;
      res_error <= ((op == OP_FREE) || (op == OP_OCCUPY)) && (len == '0);
    end
    if (cmd.q_sat) begin
      res_score <= sat;
    end
    if (cmd.out_load) begin
      m_tdata <= res_score;
      m_tuser <= res_error;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid    <= '0;
      rvalid   <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (we) begin
        valid[waddr] <= 1'b1;
      end
      if (re) begin
        rvalid <= valid[raddr];
      end
      if (cmd.out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  assign sts.op        = op;
  assign sts.len_zero  = (len == '0);
  assign sts.last_zero = (top_bucket == '0);
  assign sts.v_last    = (v == last);
  assign sts.out_busy  = m_tvalid && !m_tready;

endmodule

`default_nettype wire

// ----- design/felst_chk.sv -----
// Port-level checker for the free extent score tracker, bound to the top level.
// Depends on free_extent_log2_score_tracker_macros.svh.
`timescale 1ns / 1ps
`default_nettype none

`include "free_extent_log2_score_tracker_macros.svh"

module felst_chk (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        s_tvalid,
  input wire logic        s_tready,
  input wire logic        m_tvalid,
  input wire logic        m_tready,
  input wire logic [63:0] m_tdata,
  input wire logic        m_tuser
);

  logic       in_acc, out_acc;
  logic [1:0] pending;

  assign in_acc  = s_tvalid && s_tready;
  assign out_acc = m_tvalid && m_tready;

  // Items accepted whose result has not yet been taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
    end else if (in_acc && !out_acc) begin
      pending <= pending + 2'd1;
    end else if (out_acc && !in_acc) begin
      pending <= pending - 2'd1;
    end
  end

  `FELST_ASSERT_NEXT(a_single_item, in_acc, !s_tready)
  `FELST_ASSERT(a_error_score_zero, m_tvalid && m_tuser, m_tdata == 64'd0)
  `FELST_ASSERT(a_no_phantom, m_tvalid, pending != 2'd0)
  `FELST_ASSERT(a_pending_bound, pending == 2'd2, !s_tready)
  `FELST_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

endmodule

bind free_extent_log2_score_tracker felst_chk u_felst_chk (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);

`default_nettype wire
